FILE: rtl/swd_pkg.sv
package swd_pkg;

	localparam int MAX_WINDOW_DEF  = 64;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int FIFO_DEPTH      = 4;

	localparam int CORR_W     = 32;
	localparam int NS_W       = 34;
	localparam int SUM_W      = 41;
	localparam int V_W        = SUM_W + 1;
	localparam int MA_W       = 44;
	localparam int LH_W       = MA_W / 2;
	localparam int MB_W       = 17;
	localparam int PROD_W     = MA_W + MB_W;
	localparam int DW         = NS_W + 2;
	localparam int VAL_W      = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MODE, CFG_WINDOW_SIZE, CFG_MEAN_RECIP, CFG_GAIN,
		CFG_ADC_MIN, CFG_ADC_MAX, CFG_OUT_OFFSET, CFG_OUT_SCALE
	} cfg_idx_t;

	localparam logic [1:0] MODE_MAX   = 2'd0;
	localparam logic [1:0] MODE_NMEAN = 2'd1;
	localparam logic [1:0] MODE_MEAN  = 2'd2;

	typedef struct packed {
		logic [1:0]         mode;
		logic [6:0]         window_size;
		logic [16:0]        mean_recip;
		logic [15:0]        gain;
		logic signed [15:0] adc_min;
		logic signed [15:0] adc_max;
		logic signed [15:0] out_offset;
		logic [15:0]        out_scale;
	} cfg_t;

	typedef enum logic [1:0] {RK_BEST, RK_MEAN, RK_NMEAN} kind_t;

	typedef struct packed {
		logic                    pend_v;
		logic signed [NS_W-1:0]  pend_sum;
		logic [1:0]              pend_cnt;
		logic                    win_v;
		kind_t                   win_kind;
		logic signed [SUM_W-1:0] win_val;
		logic [1:0]              win_cnt;
		logic                    last;
	} job_t;

	typedef enum logic [2:0] {
		BS_IDLE, BS_LOAD, BS_DIV, BS_MUL_LO, BS_MUL_HI, BS_POST, BS_OUT
	} bstate_t;

	typedef enum logic [1:0] {MP_MEAN, MP_GAIN, MP_SCALE} mphase_t;

endpackage

FILE: rtl/swd_if.sv
interface swd_in_if #(parameter int SAMPLE_BITS = swd_pkg::SAMPLE_BITS_DEF);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic [15:0]                   lifetime_factor;
	logic                          last;
	modport source(output valid, sample, lifetime_factor, last, input ready);
	modport sink(input valid, sample, lifetime_factor, last, output ready);
endinterface

interface swd_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] value;
	logic               last_res;
	modport source(output valid, value, last_res, input ready);
	modport sink(input valid, value, last_res, output ready);
endinterface

FILE: rtl/sample_window_downscale.sv
// throughput: the front takes one word a cycle while the 4-entry queue has room;
// the back takes one job at a time and works it through its shared split multiplier
// reset: arst_n clears all control state and loads the register defaults
module sample_window_downscale #(
	parameter int MAX_WINDOW  = swd_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = swd_pkg::SAMPLE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [swd_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [swd_pkg::CFG_DATA_W-1:0]   cfg_data,
	swd_in_if.sink                           in_ch,
	swd_out_if.source                        out_ch
);
	import swd_pkg::*;

	cfg_t cfg_q;
	job_t job_w, head;
	logic push, full, pop, not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode        <= MODE_MAX;
			cfg_q.window_size <= 7'd10;
			cfg_q.mean_recip  <= 17'd6554;
			cfg_q.gain        <= 16'd4096;
			cfg_q.adc_min     <= -16'sd160;
			cfg_q.adc_max     <= 16'sd4000;
			cfg_q.out_offset  <= '0;
			cfg_q.out_scale   <= 16'd4096;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_MODE:        cfg_q.mode        <= cfg_data[1:0];
				CFG_WINDOW_SIZE: cfg_q.window_size <= cfg_data[6:0];
				CFG_MEAN_RECIP:  cfg_q.mean_recip  <= cfg_data[16:0];
				CFG_GAIN:        cfg_q.gain        <= cfg_data[15:0];
				CFG_ADC_MIN:     cfg_q.adc_min     <= cfg_data[15:0];
				CFG_ADC_MAX:     cfg_q.adc_max     <= cfg_data[15:0];
				CFG_OUT_OFFSET:  cfg_q.out_offset  <= cfg_data[15:0];
				CFG_OUT_SCALE:   cfg_q.out_scale   <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	swd_front #(.MAX_WINDOW(MAX_WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .in_ch(in_ch),
		.job(job_w), .job_push(push), .job_full(full)
	);

	swd_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .wr_data(job_w), .full(full),
		.pop(pop), .rd_data(head), .not_empty(not_empty)
	);

	swd_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .job(head), .job_valid(not_empty),
		.job_pop(pop), .out_ch(out_ch)
	);
endmodule

FILE: rtl/swd_fifo.sv
module swd_fifo #(
	parameter int DEPTH = swd_pkg::FIFO_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  swd_pkg::job_t wr_data,
	output logic          full,
	input  logic          pop,
	output swd_pkg::job_t rd_data,
	output logic          not_empty
);
	import swd_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full      = (cnt_q == CNT_W'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign rd_data   = mem[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= wr_data;
		end
	end
endmodule

FILE: rtl/swd_front.sv
module swd_front #(
	parameter int MAX_WINDOW  = swd_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = swd_pkg::SAMPLE_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  swd_pkg::cfg_t cfg,
	swd_in_if.sink        in_ch,
	output swd_pkg::job_t job,
	output logic          job_push,
	input  logic          job_full
);
	import swd_pkg::*;

	localparam int PW   = ($clog2(MAX_WINDOW + 1) > 7) ? $clog2(MAX_WINDOW + 1) : 7;
	localparam int PR_W = SAMPLE_BITS + 17;

	logic                          v_s1, last_s1;
	logic signed [SAMPLE_BITS-1:0] smp_s1;
	logic [15:0]                   fac_s1;
	logic                          v_s2, last_s2;
	logic signed [CORR_W-1:0]      c_s2;

	logic                     fire2, adv1, accept;
	logic signed [PR_W-1:0]   prod;
	logic signed [63:0]       p64;
	logic signed [CORR_W-1:0] c_sat;

	logic [PW-1:0]             pos_q, pos_d, pos_n, w_eff, ws_ext;
	logic signed [CORR_W-1:0]  best_q, best_d, prev_q;
	logic signed [SUM_W-1:0]   wsum_q, wsum_d;
	logic signed [NS_W-1:0]    nsum_q, nsum_d, psum_q, psum_d, c_ns;
	logic [1:0]                ncnt_q, ncnt_d, pcnt_q, pcnt_d;
	logic                      aw_q, aw_d, hp_q, pv_q, pv_d, close;

	assign fire2       = v_s2 && !job_full;
	assign adv1        = !v_s2 || fire2;
	assign in_ch.ready = !v_s1 || adv1;
	assign accept      = in_ch.valid && in_ch.ready;

	assign prod  = $signed(smp_s1) * $signed({1'b0, fac_s1});
	assign p64   = 64'(prod);
	assign c_sat = (p64 > 64'sd2147483647) ? 32'sh7fffffff :
	               (p64 < -64'sd2147483648) ? 32'sh80000000 : CORR_W'(p64);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (in_ch.ready) begin
				v_s1 <= in_ch.valid;
			end
			if (adv1) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			smp_s1  <= in_ch.sample;
			fac_s1  <= in_ch.lifetime_factor;
			last_s1 <= in_ch.last;
		end
		if (adv1 && v_s1) begin
			c_s2    <= c_sat;
			last_s2 <= last_s1;
		end
	end

	// window bookkeeping
	always_comb begin
		c_ns   = NS_W'(c_s2);
		ws_ext = PW'(cfg.window_size);
		if (ws_ext == '0) begin
			w_eff = PW'(1);
		end else if (ws_ext > PW'(MAX_WINDOW)) begin
			w_eff = PW'(MAX_WINDOW);
		end else begin
			w_eff = ws_ext;
		end

		best_d = best_q;
		wsum_d = wsum_q;
		nsum_d = nsum_q;
		ncnt_d = ncnt_q;
		aw_d   = aw_q;
		if (pos_q == '0) begin
			best_d = c_s2;
			wsum_d = SUM_W'(c_s2);
			nsum_d = c_ns + (hp_q ? NS_W'(prev_q) : '0);
			ncnt_d = hp_q ? 2'd2 : 2'd1;
			aw_d   = 1'b1;
		end else begin
			wsum_d = wsum_q + SUM_W'(c_s2);
			if (aw_q) begin
				nsum_d = nsum_q + c_ns;
				ncnt_d = ncnt_q + 2'd1;
				aw_d   = 1'b0;
			end
			if (c_s2 > best_q) begin
				best_d = c_s2;
				nsum_d = c_ns + NS_W'(prev_q);
				ncnt_d = 2'd2;
				aw_d   = 1'b1;
			end
		end
		pos_n = pos_q + 1'b1;
		close = (pos_n >= w_eff);
		pos_d = close ? '0 : pos_n;

		job.pend_v   = pv_q;
		job.pend_sum = psum_q + c_ns;
		job.pend_cnt = pcnt_q + 2'd1;
		job.win_v    = 1'b0;
		job.win_kind = RK_BEST;
		job.win_val  = SUM_W'(best_d);
		job.win_cnt  = ncnt_d;
		job.last     = last_s2;
		pv_d   = 1'b0;
		psum_d = psum_q;
		pcnt_d = pcnt_q;
		if (close) begin
			case (cfg.mode)
				MODE_NMEAN: begin
					if (aw_d && !last_s2) begin
						pv_d   = 1'b1;
						psum_d = nsum_d;
						pcnt_d = ncnt_d;
					end else begin
						job.win_v    = 1'b1;
						job.win_kind = RK_NMEAN;
						job.win_val  = SUM_W'(nsum_d);
					end
					aw_d = 1'b0;
				end
				MODE_MEAN: begin
					job.win_v    = 1'b1;
					job.win_kind = RK_MEAN;
					job.win_val  = wsum_d;
				end
				default: begin
					job.win_v = 1'b1;
				end
			endcase
		end
		job_push = fire2 && (pv_q || job.win_v);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			best_q <= '0;
			wsum_q <= '0;
			nsum_q <= '0;
			ncnt_q <= '0;
			aw_q   <= 1'b0;
			prev_q <= '0;
			hp_q   <= 1'b0;
			pv_q   <= 1'b0;
			psum_q <= '0;
			pcnt_q <= '0;
		end else if (fire2) begin
			if (last_s2) begin
				pos_q  <= '0;
				best_q <= '0;
				wsum_q <= '0;
				nsum_q <= '0;
				ncnt_q <= '0;
				aw_q   <= 1'b0;
				prev_q <= '0;
				hp_q   <= 1'b0;
				pv_q   <= 1'b0;
				psum_q <= '0;
				pcnt_q <= '0;
			end else begin
				pos_q  <= pos_d;
				best_q <= best_d;
				wsum_q <= wsum_d;
				nsum_q <= nsum_d;
				ncnt_q <= ncnt_d;
				aw_q   <= aw_d;
				prev_q <= c_s2;
				hp_q   <= 1'b1;
				pv_q   <= pv_d;
				psum_q <= psum_d;
				pcnt_q <= pcnt_d;
			end
		end
	end
endmodule

FILE: rtl/swd_back.sv
module swd_back (
	input  logic          clk,
	input  logic          arst_n,
	input  swd_pkg::cfg_t cfg,
	input  swd_pkg::job_t job,
	input  logic          job_valid,
	output logic          job_pop,
	swd_out_if.source     out_ch
);
	import swd_pkg::*;

	bstate_t                  state_q, state_d;
	mphase_t                  ph_q, ph_d;
	logic                     second_q, second_d;
	logic signed [MA_W-1:0]   a_q, a_d;
	logic [MB_W-1:0]          b_q, b_d;
	logic signed [PROD_W-1:0] prod_q, prod_d;
	logic [DW-1:0]            u_q, u_d, q_q, q_d;
	logic                     neg_q, neg_d;
	logic [3:0]               cnt_q, cnt_d;
	logic signed [VAL_W-1:0]  val_q, val_d;
	logic                     lr_q, lr_d;

	assign out_ch.valid    = (state_q == BS_OUT);
	assign out_ch.value    = val_q;
	assign out_ch.last_res = lr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		ph_q     <= ph_d;
		second_q <= second_d;
		a_q      <= a_d;
		b_q      <= b_d;
		prod_q   <= prod_d;
		u_q      <= u_d;
		q_q      <= q_d;
		neg_q    <= neg_d;
		cnt_q    <= cnt_d;
		val_q    <= val_d;
		lr_q     <= lr_d;
	end

	always_comb begin
		kind_t                          kind;
		logic signed [SUM_W-1:0]        sval;
		logic [1:0]                     scnt;
		logic signed [V_W-1:0]          t;
		logic [DW-1:0]                  qt;
		logic [34:0]                    qh;
		logic [36:0]                    rp;
		logic [LH_W+MB_W-1:0]           lo;
		logic signed [MA_W-LH_W+MB_W:0] hi;
		logic signed [PROD_W-1:0]       lim_lo, lim_hi, pc, rr;
		logic signed [24:0]             res;

		state_d  = state_q;
		ph_d     = ph_q;
		second_d = second_q;
		a_d      = a_q;
		b_d      = b_q;
		prod_d   = prod_q;
		u_d      = u_q;
		q_d      = q_q;
		neg_d    = neg_q;
		cnt_d    = cnt_q;
		val_d    = val_q;
		lr_d     = lr_q;
		job_pop  = 1'b0;

		if (second_q) begin
			kind = job.win_kind;
			sval = job.win_val;
			scnt = job.win_cnt;
		end else begin
			kind = RK_NMEAN;
			sval = SUM_W'(job.pend_sum);
			scnt = job.pend_cnt;
		end
		t      = V_W'(sval) + V_W'(1);
		qt     = q_q;
		qh     = '0;
		rp     = '0;
		lo     = a_q[LH_W-1:0] * b_q;
		hi     = $signed(a_q[MA_W-1:LH_W]) * $signed({1'b0, b_q});
		lim_lo = PROD_W'(cfg.adc_min) <<< 26;
		lim_hi = PROD_W'(cfg.adc_max) <<< 26;
		pc     = prod_q;
		rr     = (prod_q + (PROD_W'(1) <<< 37)) >>> 38;
		res    = 25'(rr) + 25'(cfg.out_offset);

		case (state_q)
			BS_IDLE: begin
				if (job_valid) begin
					second_d = !job.pend_v;
					state_d  = BS_LOAD;
				end
			end
			BS_LOAD: begin
				b_d     = {1'b0, cfg.gain};
				ph_d    = MP_GAIN;
				a_d     = MA_W'(sval);
				state_d = BS_MUL_LO;
				case (kind)
					RK_MEAN: begin
						b_d  = cfg.mean_recip;
						ph_d = MP_MEAN;
					end
					RK_NMEAN: begin
						if (scnt == 2'd3) begin
							neg_d   = t[V_W-1];
							u_d     = t[V_W-1] ? DW'(V_W'(2) - t) : DW'(t);
							q_d     = '0;
							cnt_d   = '0;
							state_d = BS_DIV;
						end else if (scnt == 2'd2) begin
							a_d = MA_W'(t >>> 1);
						end
					end
					default: begin
					end
				endcase
			end
			BS_DIV: begin
				// divide by three: split at bit 18, then a reciprocal multiply
				if (cnt_q == '0) begin
					qh    = u_q[DW-1:18] * 17'd87381;
					q_d   = DW'(qh);
					u_d   = DW'(u_q[DW-1:18]) + DW'(u_q[17:0]);
					cnt_d = 4'd1;
				end else begin
					rp      = u_q[18:0] * 18'd174763;
					qt      = q_q + DW'(rp[36:19]);
					a_d     = neg_q ? -MA_W'({1'b0, qt}) : MA_W'({1'b0, qt});
					b_d     = {1'b0, cfg.gain};
					ph_d    = MP_GAIN;
					state_d = BS_MUL_LO;
				end
			end
			BS_MUL_LO: begin
				prod_d  = PROD_W'({1'b0, lo});
				state_d = BS_MUL_HI;
			end
			BS_MUL_HI: begin
				prod_d  = prod_q + (PROD_W'(hi) <<< LH_W);
				state_d = BS_POST;
			end
			BS_POST: begin
				case (ph_q)
					MP_MEAN: begin
						a_d     = MA_W'((prod_q + PROD_W'(32768)) >>> 16);
						b_d     = {1'b0, cfg.gain};
						ph_d    = MP_GAIN;
						state_d = BS_MUL_LO;
					end
					MP_GAIN: begin
						if (prod_q < lim_lo) begin
							pc = lim_lo;
						end else if (prod_q > lim_hi) begin
							pc = lim_hi;
						end
						a_d     = MA_W'(pc - lim_lo);
						b_d     = {1'b0, cfg.out_scale};
						ph_d    = MP_SCALE;
						state_d = BS_MUL_LO;
					end
					default: begin
						if (res > 25'sd32767) begin
							val_d = 16'sh7fff;
						end else if (res < -25'sd32768) begin
							val_d = 16'sh8000;
						end else begin
							val_d = VAL_W'(res);
						end
						lr_d    = job.last && (second_q || !job.win_v);
						state_d = BS_OUT;
					end
				endcase
			end
			BS_OUT: begin
				if (out_ch.ready) begin
					if (!second_q && job.win_v) begin
						second_d = 1'b1;
						state_d  = BS_LOAD;
					end else begin
						job_pop = 1'b1;
						state_d = BS_IDLE;
					end
				end
			end
			default: begin
				state_d = BS_IDLE;
			end
		endcase
	end
endmodule

FILE: rtl/swd_checker.sv
module swd_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	a_no_early_out: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !out_valid)
		else $error("result word straight after reset");

	a_ready_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> in_ready)
		else $error("input not ready after reset");
endmodule

bind sample_window_downscale swd_checker u_swd_checker (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready)
);
